### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the serial frame receiver
// Frame bytes, phase codes, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Frame delimiters and checksum target
   localparam logic [7:0] START_BYTE     = 8'h7B;   // '{'
   localparam logic [7:0] END_BYTE       = 8'h7D;   // '}'
   localparam logic [7:0] SUM_GOOD       = 8'hFF;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
   localparam logic [7:0] MIN_LENGTH     = 8'd5;

   // Input command codes
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Deframer phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_DATA = 3'd2;
   localparam logic [2:0] PH_SUM  = 3'd3;
   localparam logic [2:0] PH_END  = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_START   = 3'd1;
   localparam logic [2:0] ERR_SUM     = 3'd2;
   localparam logic [2:0] ERR_END     = 3'd3;
   localparam logic [2:0] ERR_TIMEOUT = 3'd4;
   localparam logic [2:0] ERR_LENGTH  = 3'd5;

   // Packed result channel widths
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [7:0] position;
      logic [7:0] payload_length;
      logic [2:0] error_code;
   } rsp_type;

endpackage

### rtl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// sfr_in_stage: input register
// Capture one received byte or timeout transaction; release it on advance.
// ----------------------------------------------------------------------------
module sfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tuser,   // [0] cmd
   input  logic       advance,
   output logic       item_valid,
   output logic       item_cmd,
   output logic [7:0] item_byte
);
   import sfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic       cmd_ff;
   logic [7:0] byte_ff;
   logic       load;

   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff  <= req_tuser;
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_cmd   = cmd_ff;
   assign item_byte  = byte_ff;

endmodule

### rtl/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core: deframing state and per-byte decision
// Hold phase, length, index and running sum; decide the result of one item.
// ----------------------------------------------------------------------------
module sfr_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             item_cmd,
   input  logic [7:0]       item_byte,
   output sfr_pkg::rsp_type result
);
   import sfr_pkg::*;

   logic [2:0] phase_ff,    phase_in;
   logic [7:0] exp_len_ff,  exp_len_in;
   logic [7:0] index_ff,    index_in;
   logic [7:0] sum_ff,      sum_in;
   rsp_type    res;

   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      index_in   = index_ff;
      sum_in     = sum_ff;
      res        = '0;
      if (step) begin
         if (item_cmd == CMD_TIMEOUT) begin
            // error only mid-frame (a stray phase code counts as idle);
            // either way drop back to idle
            if ((phase_ff != PH_IDLE) && (phase_ff <= PH_END)) begin
               res.valid      = 1'b1;
               res.kind       = KIND_ERR;
               res.error_code = ERR_TIMEOUT;
            end
            phase_in   = PH_IDLE;
            exp_len_in = '0;
            index_in   = '0;
            sum_in     = '0;
         end else begin
            unique case (phase_ff)
               PH_LEN: begin
                  if (item_byte < MIN_LENGTH) begin
                     res.valid      = 1'b1;
                     res.kind       = KIND_ERR;
                     res.error_code = ERR_LENGTH;
                     phase_in       = PH_IDLE;
                     exp_len_in     = '0;
                     index_in       = '0;
                     sum_in         = '0;
                  end else begin
                     exp_len_in = 8'(item_byte - FRAME_OVERHEAD);
                     sum_in     = item_byte;
                     index_in   = '0;
                     phase_in   = PH_DATA;
                  end
               end
               PH_DATA: begin
                  res.valid        = 1'b1;
                  res.kind         = KIND_DATA;
                  res.payload_byte = item_byte;
                  res.position     = index_ff;
                  sum_in           = 8'(sum_ff + item_byte);
                  index_in         = 8'(index_ff + 8'd1);
                  if (index_in >= exp_len_ff) begin
                     phase_in = PH_SUM;
                  end
               end
               PH_SUM: begin
                  if (8'(sum_ff + item_byte) == SUM_GOOD) begin
                     phase_in = PH_END;
                  end else begin
                     res.valid      = 1'b1;
                     res.kind       = KIND_ERR;
                     res.error_code = ERR_SUM;
                     phase_in       = PH_IDLE;
                     exp_len_in     = '0;
                     index_in       = '0;
                     sum_in         = '0;
                  end
               end
               PH_END: begin
                  res.valid = 1'b1;
                  if (item_byte == END_BYTE) begin
                     res.kind           = KIND_OK;
                     res.payload_length = exp_len_ff;
                  end else begin
                     res.kind       = KIND_ERR;
                     res.error_code = ERR_END;
                  end
                  phase_in   = PH_IDLE;
                  exp_len_in = '0;
                  index_in   = '0;
                  sum_in     = '0;
               end
               default: begin
                  // idle, and any stray phase code behaves as idle
                  if (item_byte != START_BYTE) begin
                     res.valid      = 1'b1;
                     res.kind       = KIND_ERR;
                     res.error_code = ERR_START;
                  end
                  phase_in   = (item_byte == START_BYTE) ? PH_LEN : PH_IDLE;
                  exp_len_in = '0;
                  index_in   = '0;
                  sum_in     = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         exp_len_ff <= '0;
         index_ff   <= '0;
         sum_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         exp_len_ff <= exp_len_in;
         index_ff   <= index_in;
         sum_ff     <= sum_in;
      end
   end

   assign result = res;

`ifndef SYNTH
   // payload phase never runs past the announced length
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (index_ff < exp_len_ff))
      else $error("payload index reached expected length in data phase");

   // checksum phase is entered only with the whole payload counted
   a_sum_after_full_payload: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SUM) |-> (index_ff == exp_len_ff))
      else $error("checksum phase with partial payload");

   // every error leaves the deframer idle
   a_error_to_idle: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == KIND_ERR) |=> (phase_ff == PH_IDLE))
      else $error("deframer not idle after error");

   // a completed frame always reports a nonzero payload
   a_ok_has_length: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.kind == KIND_OK) |-> (res.payload_length != 8'd0))
      else $error("frame complete with empty payload");
`endif

endmodule

### rtl/sfr_out_stage.sv
// ----------------------------------------------------------------------------
// sfr_out_stage: result register
// Hold one result transaction until the sink takes it; pack it for the bus.
// ----------------------------------------------------------------------------
module sfr_out_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  sfr_pkg::rsp_type                    result,
   output logic                                advance,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [15:8] position, [23:16] payload_length,
   // [26:24] error_code, [31:27] zero
   output logic [sfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sfr_pkg::RSP_USER_W-1:0]      rsp_tuser   // [1:0] kind
);
   import sfr_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type res_ff;

   // register is free when empty or being drained this cycle
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {5'b0, res_ff.error_code, res_ff.payload_length,
                        res_ff.position, res_ff.payload_byte};

endmodule

### rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver: byte-wide deframer with additive checksum
// Strip '{' L payload sum '}' frames, emit each payload byte and a status.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                              | tuser
//  --------+-----------+------------------------------------+----------------
//  req_    | in        | [7:0] rx_byte                      | [0] cmd
//  rsp_    | out       | [7:0] payload_byte [15:8] position | [1:0] kind
//          |           | [23:16] payload_length             |
//          |           | [26:24] error_code                 |
//
//  Throughput is one transaction per clock while rsp_ is not stalled: the
//  per-byte decision in sfr_core is a single compare/add between the input
//  register and the result register, which drives rsp_tvalid.
//  Reset is synchronous, active high; the deframer returns to idle awaiting '{'.
//  A stalled rsp_ side holds the result register and the input register; the
//  input register still takes a transaction while it is empty.
//  A byte that completes no result (start, length, good checksum) emits nothing.
//
module serial_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] rx_byte
   input  logic                                req_tuser,   // [0] cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [15:8] position, [23:16] payload_length,
   // [26:24] error_code, [31:27] zero
   output logic [sfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sfr_pkg::RSP_USER_W-1:0]      rsp_tuser    // [1:0] kind
);
   import sfr_pkg::*;

   logic       advance;
   logic       item_valid;
   logic       item_cmd;
   logic [7:0] item_byte;
   logic       step;
   rsp_type    result;

   // hold the captured transaction until the result register can move
   sfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item_cmd   (item_cmd),
      .item_byte  (item_byte)
   );

   // advance the deframer state exactly once per captured transaction
   assign step = item_valid && advance;

   sfr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_cmd  (item_cmd),
      .item_byte (item_byte),
      .result    (result)
   );

   sfr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/tb_serial_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver: self-checking bench for the byte frame deframer
// Drives '{' L payload checksum '}' frames, broken frames, stray bytes and
// receive timeouts into req_, predicts every result with a behavioral
// deframer, and checks each rsp_ transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver;
   import sfr_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RANDOM_ITEMS = 960;
   localparam int DRAIN_CYCLES = 8;        // extra clocks to wait once no result is outstanding
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 40;

   // ways a generated frame can be broken
   typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_END, FLAW_TIMEOUT, FLAW_LENGTH} frame_flaw_type;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [7:0] position;
      logic [7:0] payload_length;
      logic [2:0] error_code;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = CMD_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // deframer state as the bench sees it
   logic [2:0]  rx_phase = PH_IDLE;
   logic [7:0]  frame_payload_len = 8'h00;
   logic [7:0]  payload_count = 8'h00;
   logic [7:0]  frame_sum = 8'h00;

   frame_result_type expected_results[$];
   int unsigned   items_sent = 0;
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   bit            steady = 1'b0;           // suppress idling on both sides

   serial_frame_receiver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   task automatic clear_frame();
      rx_phase          = PH_IDLE;
      frame_payload_len = 8'h00;
      payload_count     = 8'h00;
      frame_sum         = 8'h00;
   endtask

   task automatic expect_result(logic [1:0] kind, logic [7:0] data, logic [7:0] pos,
                                logic [7:0] len, logic [2:0] err);
      frame_result_type r;
      r.kind           = kind;
      r.payload_byte   = data;
      r.position       = pos;
      r.payload_length = len;
      r.error_code     = err;
      expected_results.push_back(r);
   endtask

   // advance the predicted deframer by one accepted transaction
   task automatic predict_deframe(logic cmd, logic [7:0] rx);
      logic [7:0] pos;
      if (rx_phase > PH_END)
         clear_frame();
      if (cmd == CMD_TIMEOUT) begin
         // a timeout only matters once a frame has started
         if (rx_phase != PH_IDLE) begin
            clear_frame();
            expect_result(KIND_ERR, 8'h00, 8'h00, 8'h00, ERR_TIMEOUT);
         end
         return;
      end
      case (rx_phase)
         PH_IDLE: begin
            clear_frame();
            if (rx == START_BYTE)
               rx_phase = PH_LEN;
            else
               expect_result(KIND_ERR, 8'h00, 8'h00, 8'h00, ERR_START);
         end
         PH_LEN: begin
            if (rx < MIN_LENGTH) begin
               clear_frame();
               expect_result(KIND_ERR, 8'h00, 8'h00, 8'h00, ERR_LENGTH);
            end else begin
               frame_payload_len = rx - FRAME_OVERHEAD;
               frame_sum         = rx;
               payload_count     = 8'h00;
               rx_phase          = PH_DATA;
            end
         end
         PH_DATA: begin
            pos           = payload_count;
            frame_sum     = frame_sum + rx;
            payload_count = payload_count + 8'd1;
            if (payload_count >= frame_payload_len)
               rx_phase = PH_SUM;
            expect_result(KIND_DATA, rx, pos, 8'h00, ERR_NONE);
         end
         PH_SUM: begin
            if (8'(frame_sum + rx) == SUM_GOOD)
               rx_phase = PH_END;
            else begin
               clear_frame();
               expect_result(KIND_ERR, 8'h00, 8'h00, 8'h00, ERR_SUM);
            end
         end
         default: begin
            if (rx == END_BYTE)
               expect_result(KIND_OK, 8'h00, 8'h00, frame_payload_len, ERR_NONE);
            else
               expect_result(KIND_ERR, 8'h00, 8'h00, 8'h00, ERR_END);
            clear_frame();
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_error(string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // compare every rsp_ transaction against the oldest expectation
   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_error($sformatf("unexpected result kind %0d tdata 0x%0h",
                                   rsp_tuser, rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(rsp_tuser[1:0]), 32'(want.kind));
            check_field("payload_byte", 32'(rsp_tdata[7:0]), 32'(want.payload_byte));
            check_field("position", 32'(rsp_tdata[15:8]), 32'(want.position));
            check_field("payload_length", 32'(rsp_tdata[23:16]),
                        32'(want.payload_length));
            check_field("error_code", 32'(rsp_tdata[26:24]), 32'(want.error_code));
            check_field("tdata pad", 32'(rsp_tdata[31:27]), 32'd0);
         end
      end
   end

   // stall the result side about a third of the time unless running steady
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99, 0) >= 32);

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   // Offer one transaction and hold it until accepted; valid stays high after
   // return so back-to-back items do not drop and raise it in one step.
   task automatic send_item(logic cmd, logic [7:0] rx);
      while (!steady && $urandom_range(99, 0) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_deframe(cmd, rx);
      items_sent++;
   endtask

   // Send one frame of random payload; a flaw breaks it at a chosen spot.
   task automatic send_frame(logic [7:0] frame_len, frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] check;
      logic [7:0] rx;
      int         n;
      int         cut;
      n   = int'(frame_len) - int'(FRAME_OVERHEAD);
      // cut: 0 replaces the length, 1..n a payload byte, n+1 the checksum,
      // n+2 the end brace
      cut = (flaw == FLAW_TIMEOUT) ? int'($urandom_range(n + 2, 0)) : -1;
      send_item(CMD_BYTE, START_BYTE);
      if (cut == 0) begin
         send_item(CMD_TIMEOUT, 8'($urandom_range(255, 0)));
         return;
      end
      send_item(CMD_BYTE, frame_len);
      if (flaw == FLAW_LENGTH)
         return;
      sum = frame_len;
      for (int i = 0; i < n; i++) begin
         if (cut == i + 1) begin
            send_item(CMD_TIMEOUT, 8'($urandom_range(255, 0)));
            return;
         end
         rx  = 8'($urandom_range(255, 0));
         sum = sum + rx;
         send_item(CMD_BYTE, rx);
      end
      if (cut == n + 1) begin
         send_item(CMD_TIMEOUT, 8'($urandom_range(255, 0)));
         return;
      end
      check = SUM_GOOD - sum;
      if (flaw == FLAW_SUM)
         check = check ^ 8'($urandom_range(255, 1));
      send_item(CMD_BYTE, check);
      if (cut == n + 2) begin
         send_item(CMD_TIMEOUT, 8'($urandom_range(255, 0)));
         return;
      end
      rx = END_BYTE;
      if (flaw == FLAW_END) begin
         rx = 8'($urandom_range(255, 0));
         if (rx == END_BYTE)
            rx = ~rx;
      end
      send_item(CMD_BYTE, rx);
   endtask

   // idle timeout, stray bytes, short lengths, and breaks in each later phase
   task automatic test_framing_errors();
      send_item(CMD_TIMEOUT, 8'hFF);             // ignored while idle
      send_item(CMD_BYTE, 8'h00);                // bad start
      send_item(CMD_BYTE, 8'hFF);                // bad start
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, 8'h00);                // zero length
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, 8'h04);                // one below the shortest frame
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, 8'h06);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_TIMEOUT, 8'h00);             // timeout inside the payload
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, 8'h05);
      send_item(CMD_BYTE, END_BYTE);             // brace as payload
      send_item(CMD_BYTE, 8'h00);                // wrong checksum
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, 8'h05);
      send_item(CMD_BYTE, START_BYTE);           // brace as payload
      send_item(CMD_BYTE, SUM_GOOD - 8'h05 - START_BYTE);
      send_item(CMD_BYTE, 8'h00);                // wrong end byte
   endtask

   // one-byte payload, the smallest legal frame
   task automatic test_shortest_frame();
      send_item(CMD_BYTE, START_BYTE);
      send_item(CMD_BYTE, MIN_LENGTH);
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, SUM_GOOD - MIN_LENGTH - 8'hFF);
      send_item(CMD_BYTE, END_BYTE);
   endtask

   // full 251-byte payload: positions run to their top value
   task automatic test_longest_frame();
      send_frame(8'hFF, FLAW_NONE);
   endtask

   // mostly good frames of random content, with broken frames and noise
   task automatic test_random_traffic();
      frame_flaw_type flaw;
      logic [7:0]  frame_len;
      logic [7:0]  rx;
      int unsigned stop_at;
      int          pick;
      int          frame_no;
      stop_at  = items_sent + RANDOM_ITEMS;
      frame_no = 0;
      while (items_sent < stop_at) begin
         steady = (frame_no >= 20) && (frame_no < 45);
         if ($urandom_range(99, 0) < 15) begin
            repeat ($urandom_range(3, 1)) begin
               rx = 8'($urandom_range(255, 0));
               if ($urandom_range(1, 0) == 0)
                  send_item(CMD_TIMEOUT, rx);
               else begin
                  if (rx == START_BYTE)
                     rx = ~rx;
                  send_item(CMD_BYTE, rx);
               end
            end
         end
         pick = $urandom_range(99, 0);
         if (pick < 65)
            flaw = FLAW_NONE;
         else if (pick < 74)
            flaw = FLAW_SUM;
         else if (pick < 82)
            flaw = FLAW_END;
         else if (pick < 92)
            flaw = FLAW_TIMEOUT;
         else
            flaw = FLAW_LENGTH;
         if (flaw == FLAW_LENGTH)
            frame_len = 8'($urandom_range(4, 0));
         else if ($urandom_range(9, 0) == 0)
            frame_len = 8'($urandom_range(255, 17));
         else
            frame_len = 8'($urandom_range(16, 5));
         send_frame(frame_len, flaw);
         frame_no++;
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : run
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_framing_errors();
      test_shortest_frame();
      test_longest_frame();
      test_random_traffic();
      // release the input, then let every expected result arrive
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_results.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
rtl/sfr_pkg.sv
rtl/sfr_in_stage.sv
rtl/sfr_core.sv
rtl/sfr_out_stage.sv
rtl/serial_frame_receiver.sv
bench/tb_serial_frame_receiver.sv
